FILE: rtl/bitmap_alloc_find_first_unit_macros.svh
// Assertion macros of the bitmap allocator RTL.
`ifndef BITMAP_ALLOC_FIND_FIRST_UNIT_MACROS_SVH
`define BITMAP_ALLOC_FIND_FIRST_UNIT_MACROS_SVH

// Check on every clock edge outside reset.
`define BAFU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check on every clock edge, reset included.
`define BAFU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/bafu_pkg.sv
// Shared types, constants and helper function of the bitmap allocator.
package bafu_pkg;

   localparam int WORD_BITS        = 64;
   localparam int MAP_BITS_DEFAULT = 4096;
   localparam int FUNC_W           = 2;
   localparam int BIT_NUMBER_W     = 12;
   localparam int POSITION_W       = 12;
   localparam int BYTES_W          = 10;

   localparam logic [BYTES_W-1:0] BYTES_RESET = 10'd512;

   localparam logic [FUNC_W-1:0] FUNC_SET        = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FIND_CLEAR = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FIND_SET   = 2'd3;

   typedef struct packed {
      logic                  strobe;
      logic [POSITION_W-1:0] position;
      logic                  found;
      logic                  range_error;
   } rsp_type;

   // Index of the lowest set bit of a map word; zero when none is set.
   function automatic logic [5:0] first_one(input logic [WORD_BITS-1:0] v);
      logic [5:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = 6'(i);
         end
      end
      return idx;
   endfunction

endpackage

FILE: rtl/bafu_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
module bafu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bafu_ctrl.sv
// Request sequencer: clearing pass, read-modify-write of one word, word-wide scan.
`include "bitmap_alloc_find_first_unit_macros.svh"

module bafu_ctrl
   import bafu_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEFAULT,
   parameter int WORDS    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS,
   parameter int ADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1,
   parameter int CMP_W    = (ADDR_W + 4 > BYTES_W) ? ADDR_W + 4 : BYTES_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [BIT_NUMBER_W-1:0] req_bit_number,
   input  logic [CMP_W-1:0]        active_bytes,
   output logic                    ram_wr_en,
   output logic [ADDR_W-1:0]       ram_wr_addr,
   output logic [WORD_BITS-1:0]    ram_wr_data,
   output logic [ADDR_W-1:0]       ram_rd_addr,
   input  logic [WORD_BITS-1:0]    ram_rd_data,
   output rsp_type                 rsp
);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_MODIFY = 4'b0100,
      ST_SCAN   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              want_set_ff, want_set_in;
   logic              set_op_ff, set_op_in;
   logic [5:0]        bit_ff, bit_in;
   rsp_type           rsp_ff, rsp_in;

   logic                 accept;
   logic                 is_write;
   logic [CMP_W-1:0]     byte_idx;
   logic [CMP_W-1:0]     word_idx;
   logic                 range_err;
   logic [CMP_W-1:0]     rem;
   logic [3:0]           valid_bytes;
   logic                 last_word;
   logic [WORD_BITS-1:0] byte_mask;
   logic [WORD_BITS-1:0] hits;
   logic [WORD_BITS-1:0] one_hot;
   logic [ADDR_W+5:0]    pos_full;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign is_write = (req_func inside {FUNC_SET, FUNC_CLEAR});
   assign byte_idx = CMP_W'(req_bit_number[BIT_NUMBER_W-1:3]);
   assign word_idx = CMP_W'(req_bit_number[BIT_NUMBER_W-1:6]);
   assign range_err = (byte_idx >= active_bytes);

   // Bytes of the current word that lie inside the active range.
   assign rem         = active_bytes - CMP_W'({ptr_ff, 3'b000});
   assign valid_bytes = (rem >= CMP_W'(8)) ? 4'd8 : rem[3:0];
   assign last_word   = (rem <= CMP_W'(8));

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         byte_mask[8*k +: 8] = {8{4'(k) < valid_bytes}};
      end
   end

   assign hits     = (want_set_ff ? ram_rd_data : ~ram_rd_data) & byte_mask;
   assign pos_full = {ptr_ff, first_one(hits)};
   assign one_hot  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_ff;

   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      want_set_in = want_set_ff;
      set_op_in   = set_op_ff;
      bit_in      = bit_ff;
      rsp_in      = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_ff;
      ram_wr_data = '0;
      ram_rd_addr = ptr_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (ptr_ff == ADDR_W'(WORDS - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (is_write) begin
                  if (range_err) begin
                     rsp_in.strobe      = 1'b1;
                     rsp_in.range_error = 1'b1;
                  end else begin
                     ram_rd_addr = word_idx[ADDR_W-1:0];
                     ptr_in      = word_idx[ADDR_W-1:0];
                     bit_in      = req_bit_number[5:0];
                     set_op_in   = (req_func == FUNC_SET);
                     state_in    = ST_MODIFY;
                  end
               end else if (active_bytes == '0) begin
                  rsp_in.strobe = 1'b1;
               end else begin
                  ram_rd_addr = '0;
                  ptr_in      = '0;
                  want_set_in = (req_func == FUNC_FIND_SET);
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_MODIFY: begin
            // Read data of the addressed word arrives now: merge and write back.
            ram_wr_en     = 1'b1;
            ram_wr_data   = set_op_ff ? (ram_rd_data | one_hot) : (ram_rd_data & ~one_hot);
            rsp_in.strobe = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            if (|hits) begin
               rsp_in.strobe   = 1'b1;
               rsp_in.found    = 1'b1;
               rsp_in.position = POSITION_W'(pos_full);
               state_in        = ST_IDLE;
            end else if (last_word) begin
               rsp_in.strobe = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               ptr_in      = ptr_ff + 1'b1;
               ram_rd_addr = ptr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ptr_ff   <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         rsp_ff   <= rsp_in;
      end
      want_set_ff <= want_set_in;
      set_op_ff   <= set_op_in;
      bit_ff      <= bit_in;
   end

   assign rsp = rsp_ff;

   `BAFU_ASSERT_ALWAYS(a_reset_clears, reset |=> (state_ff == ST_CLEAR),
                       "reset must start clear pass")
   `BAFU_ASSERT(a_write_to_modify, accept && is_write && !range_err |=> (state_ff == ST_MODIFY),
                "in-range write must modify")
   `BAFU_ASSERT(a_modify_responds, (state_ff == ST_MODIFY) |=> rsp_ff.strobe,
                "modify must give a beat")
   `BAFU_ASSERT(a_found_from_scan, rsp_ff.found |-> $past(state_ff == ST_SCAN),
                "found only after scan")

endmodule

FILE: rtl/bitmap_alloc_find_first_unit.sv
// Top level of the allocation bitmap with find-first-clear and find-first-set search.
//
// Usage:
//  - Request channel: drive req_func and req_bit_number with start high; a beat is taken at
//    a rising edge where start is high and busy is low. Functions: set bit, clear bit,
//    find first clear bit, find first set bit.
//  - Response channel: each request gives one beat, shown for a single cycle with
//    rsp_strobe high. The receiver cannot stall; capture it in that cycle.
//  - Config: csr_write_data is written to the bytes-in-use register when
//    csr_write_enable is high; write only while the unit is idle. Values above
//    MAP_BITS/8 act as MAP_BITS/8.
//  - Operation: an in-range set or clear reads and writes back one 64-bit map word, with
//    busy high during the write-back. A search reads one word a cycle from word 0 up
//    until a hit or the end of the range, at most 64 words at the default size, with busy
//    high. An out-of-range set or clear, or a search over zero bytes, answers in the next
//    cycle without going busy. The single RAM read port sets the scan rate.
//  - Reset: the map is cleared by a pass that writes zero to one word a cycle over the
//    whole map, with busy high; config writes are still taken. Bytes in use resets to 512.
module bitmap_alloc_find_first_unit
   import bafu_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [BIT_NUMBER_W-1:0] req_bit_number,
   output logic                    rsp_strobe,
   output logic [POSITION_W-1:0]   rsp_position,
   output logic                    rsp_found,
   output logic                    rsp_range_error,
   input  logic                    csr_write_enable,
   input  logic [BYTES_W-1:0]      csr_write_data
);

   localparam int WORDS     = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CMP_W     = (ADDR_W + 4 > BYTES_W) ? ADDR_W + 4 : BYTES_W;
   localparam int MAP_BYTES = MAP_BITS / 8;

   logic [BYTES_W-1:0]   bytes_in_use_ff;
   logic [CMP_W-1:0]     active_bytes;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;
   rsp_type              rsp;

   // Hold the bytes-in-use register; take a write on any enabled cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_in_use_ff <= BYTES_RESET;
      end else if (csr_write_enable) begin
         bytes_in_use_ff <= csr_write_data;
      end
   end

   // Clamp the byte count to the size of the map.
   assign active_bytes = (CMP_W'(bytes_in_use_ff) > CMP_W'(MAP_BYTES)) ?
                         CMP_W'(MAP_BYTES) : CMP_W'(bytes_in_use_ff);

   // Map storage: eight map bytes per word, byte k of word w is map byte 8w+k.
   bafu_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS),
      .AW    (ADDR_W)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bafu_ctrl #(
      .MAP_BITS (MAP_BITS),
      .WORDS    (WORDS),
      .ADDR_W   (ADDR_W),
      .CMP_W    (CMP_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_bit_number (req_bit_number),
      .active_bytes   (active_bytes),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .rsp            (rsp)
   );

   // Drive the response beat from the registered result.
   assign rsp_strobe      = rsp.strobe;
   assign rsp_position    = rsp.position;
   assign rsp_found       = rsp.found;
   assign rsp_range_error = rsp.range_error;

endmodule
